// ----- sv/car_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers of the common adjacency run finder.
// No dependencies; every other file of the block but car_ram uses this package.
package car_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VAL_W            = 11;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    localparam logic [VAL_W-1:0] RUN_START_LEN = VAL_W'(2);

    // result queue: four slots kept free for the items that may still land
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = QAW + 1;
    localparam int QROOM  = QDEPTH - 4;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_STREAM = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef struct packed {
        logic [VAL_W-1:0] run_length;
        logic             run_valid;
        logic [VAL_W-1:0] run_total;
        logic             done_res;
    } t_res;

    // accepted item as seen by the run tracker
    typedef struct packed {
        logic             stream;
        logic             load;
        logic             in_range;
        logic             last;
        logic [VAL_W-1:0] element;
        logic [VAL_W-1:0] rank_value;
    } t_s0;

    // up to two results per item, packed from slot 0
    typedef struct packed {
        logic v0;
        logic v1;
        t_res r0;
        t_res r1;
    } t_push;

    function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
        return (v == VAL_MAX) ? v : v + VAL_W'(1);
    endfunction

endpackage

// ----- sv/car_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the run finder: input items and result items.
// Depends on car_pkg for field widths.
interface car_item_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [car_pkg::VAL_W-1:0] element;
    logic [car_pkg::VAL_W-1:0] rank_value;
    logic                      last;

    modport source (output valid, action, element, rank_value, last, input ready);
    modport sink   (input valid, action, element, rank_value, last, output ready);
endinterface

interface car_res_if;
    logic                      valid;
    logic                      ready;
    logic [car_pkg::VAL_W-1:0] run_length;
    logic                      run_valid;
    logic [car_pkg::VAL_W-1:0] run_total;
    logic                      done_res;

    modport source (output valid, run_length, run_valid, run_total, done_res, input ready);
    modport sink   (input valid, run_length, run_valid, run_total, done_res, output ready);
endinterface

// ----- sv/car_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module car_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/car_track.sv -----
`timescale 1ns / 1ps
// Run tracker: second stage of a streamed element, pair test and run state.
// Depends on car_pkg; takes rank read data from the rank table RAM.
module car_track (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  car_pkg::t_s0                i_s0,
    input  logic [car_pkg::VAL_W-1:0]   i_rdata,
    output car_pkg::t_push              o_push
);

    logic                      r_s1_valid;
    logic                      r_s1_inr;
    logic                      r_s1_last;
    logic [car_pkg::VAL_W-1:0] r_s1_elem;

    logic [car_pkg::VAL_W-1:0] r_prev_elem, n_prev_elem;
    logic [car_pkg::VAL_W-1:0] r_prev_rank, n_prev_rank;
    logic                      r_have_prev, n_have_prev;
    car_pkg::t_dir             r_dir, n_dir;
    logic [car_pkg::VAL_W-1:0] r_len, n_len;
    logic [car_pkg::VAL_W-1:0] r_runs, n_runs;

    logic [car_pkg::VAL_W-1:0] b_rank;
    logic [car_pkg::VAL_W:0]   a_rank_inc;
    logic                      adj;
    car_pkg::t_dir             pair_dir;
    logic                      emit0;
    car_pkg::t_dir             dir0;
    logic [car_pkg::VAL_W-1:0] len0;
    logic [car_pkg::VAL_W-1:0] runs0;
    logic [car_pkg::VAL_W-1:0] runs1;
    car_pkg::t_res             res_pair;
    car_pkg::t_res             res_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_s0.stream;
        end
        r_s1_inr  <= i_s0.in_range;
        r_s1_last <= i_s0.last;
        r_s1_elem <= i_s0.element;
    end

    assign b_rank     = r_s1_inr ? i_rdata : '0;
    assign a_rank_inc = {1'b0, r_prev_rank} + (car_pkg::VAL_W+1)'(1);
    assign adj        = a_rank_inc == {1'b0, b_rank};
    assign pair_dir   = (r_prev_elem < r_s1_elem) ? car_pkg::DIR_UP : car_pkg::DIR_DOWN;

    always_comb begin
        emit0 = 1'b0;
        dir0  = r_dir;
        len0  = r_len;
        if (r_have_prev) begin
            if (adj) begin
                if (r_dir == pair_dir) begin
                    len0 = car_pkg::sat_inc(r_len);
                end else begin
                    emit0 = r_dir != car_pkg::DIR_NONE;
                    dir0  = pair_dir;
                    len0  = car_pkg::RUN_START_LEN;
                end
            end else if (r_dir != car_pkg::DIR_NONE) begin
                emit0 = 1'b1;
                dir0  = car_pkg::DIR_NONE;
                len0  = car_pkg::RUN_START_LEN;
            end
        end
        runs0 = emit0 ? car_pkg::sat_inc(r_runs) : r_runs;
        runs1 = (dir0 != car_pkg::DIR_NONE) ? car_pkg::sat_inc(runs0) : runs0;

        res_pair.run_length = r_len;
        res_pair.run_valid  = 1'b1;
        res_pair.run_total  = runs0;
        res_pair.done_res   = 1'b0;

        res_close.run_valid  = dir0 != car_pkg::DIR_NONE;
        res_close.run_length = res_close.run_valid ? len0 : '0;
        res_close.run_total  = runs1;
        res_close.done_res   = 1'b1;

        // compact results from slot 0
        o_push.v0 = r_s1_valid && (emit0 || r_s1_last);
        o_push.v1 = r_s1_valid && emit0 && r_s1_last;
        o_push.r0 = emit0 ? res_pair : res_close;
        o_push.r1 = res_close;
    end

    always_comb begin
        n_prev_elem = r_prev_elem;
        n_prev_rank = r_prev_rank;
        n_have_prev = r_have_prev;
        n_dir       = r_dir;
        n_len       = r_len;
        n_runs      = r_runs;
        if (r_s1_valid) begin
            if (r_s1_last) begin
                n_prev_elem = '0;
                n_have_prev = 1'b0;
                n_dir       = car_pkg::DIR_NONE;
                n_len       = car_pkg::RUN_START_LEN;
                n_runs      = '0;
            end else begin
                n_prev_elem = r_s1_elem;
                n_have_prev = 1'b1;
                n_dir       = dir0;
                n_len       = len0;
                n_runs      = runs0;
            end
            // a load in the first stage rewrites the rank just read
            n_prev_rank = (i_s0.load && i_s0.element == r_s1_elem) ? i_s0.rank_value : b_rank;
        end else if (i_s0.load && r_have_prev && i_s0.element == r_prev_elem) begin
            n_prev_rank = i_s0.rank_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_elem <= '0;
            r_have_prev <= 1'b0;
            r_dir       <= car_pkg::DIR_NONE;
            r_len       <= car_pkg::RUN_START_LEN;
            r_runs      <= '0;
        end else begin
            r_prev_elem <= n_prev_elem;
            r_have_prev <= n_have_prev;
            r_dir       <= n_dir;
            r_len       <= n_len;
            r_runs      <= n_runs;
        end
        r_prev_rank <= n_prev_rank;
    end

endmodule

// ----- sv/car_outq.sv -----
`timescale 1ns / 1ps
// Result queue: takes up to two results a cycle, presents one per handshake.
// Depends on car_pkg and the car_res_if channel.
module car_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  car_pkg::t_push i_push,
    output logic           o_room,
    car_res_if.source      o_res
);

    car_pkg::t_res             r_q [car_pkg::QDEPTH];
    logic [car_pkg::QAW-1:0]   r_wptr, r_rptr;
    logic [car_pkg::QCW-1:0]   r_cnt;
    logic                      pop;
    logic [car_pkg::QCW-1:0]   n_push;
    logic [car_pkg::QAW-1:0]   wptr1;

    assign pop    = o_res.valid && o_res.ready;
    assign n_push = car_pkg::QCW'(i_push.v0) + car_pkg::QCW'(i_push.v1);
    assign wptr1  = r_wptr + car_pkg::QAW'(1);
    assign o_room = r_cnt <= car_pkg::QCW'(car_pkg::QROOM);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_q[r_wptr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_q[wptr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= r_wptr + car_pkg::QAW'(n_push);
            if (pop) begin
                r_rptr <= r_rptr + car_pkg::QAW'(1);
            end
            r_cnt <= r_cnt + n_push - car_pkg::QCW'(pop);
        end
    end

    assign o_res.valid      = r_cnt != '0;
    assign o_res.run_length = r_q[r_rptr].run_length;
    assign o_res.run_valid  = r_q[r_rptr].run_valid;
    assign o_res.run_total  = r_q[r_rptr].run_total;
    assign o_res.done_res   = r_q[r_rptr].done_res;

endmodule

// ----- sv/common_adjacency_run_finder.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle; the input stalls only while the result queue holds
//   more than four results. Each accepted item costs one rank table RAM access.
// Results: an accepted item is registered into the tracker stage, and its results are then
//   written into the queue; two results of one item (a run and the closing item) go in together.
// Reset (i_rst_n low, synchronous): clears run state and the result queue. The
//   rank table is not cleared; an entry reads undefined until loaded.
module common_adjacency_run_finder #(
    parameter int MAX_ELEMENTS = car_pkg::MAX_ELEMENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    car_item_if.sink  i_item,
    car_res_if.source o_res
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    logic                      room;
    logic                      acc;
    logic                      in_range;
    logic [AW-1:0]             addr;
    logic [car_pkg::VAL_W-1:0] rdata;
    car_pkg::t_s0              s0;
    car_pkg::t_push            push;

    // Accept while the queue can still hold everything in flight: the item in
    // the tracker stage and the new one may each add two results.
    assign i_item.ready = room;
    assign acc          = i_item.valid && i_item.ready;

    // Elements 1..MAX_ELEMENTS map to table rows 0..MAX_ELEMENTS-1; anything
    // else has rank zero and is never written to the table.
    assign in_range = (i_item.element != '0) && (32'(i_item.element) <= MAX_ELEMENTS);
    assign addr     = AW'(32'(i_item.element) - 32'd1);

    // First stage: a load writes the table now; a streamed element reads its
    // rank, which arrives with the element in the tracker stage next cycle.
    always_comb begin
        s0.stream     = acc && (i_item.action == car_pkg::ACT_STREAM);
        s0.load       = acc && (i_item.action == car_pkg::ACT_LOAD) && in_range;
        s0.in_range   = in_range;
        s0.last       = i_item.last;
        s0.element    = i_item.element;
        s0.rank_value = i_item.rank_value;
    end

    car_ram #(
        .WIDTH (car_pkg::VAL_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_rank (
        .i_clk   (i_clk),
        .i_we    (s0.load),
        .i_waddr (addr),
        .i_wdata (i_item.rank_value),
        .i_re    (s0.stream),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // Second stage: pair test against the held previous rank, run update.
    // The previous rank is forwarded from a load that hits its element.
    car_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s0    (s0),
        .i_rdata (rdata),
        .o_push  (push)
    );

    // Results wait here, so the input side keeps moving during output stalls.
    car_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

// ----- sv/car_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the run finder's result channel, bound to the top level.
// Depends on car_pkg for field widths.
module car_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [car_pkg::VAL_W-1:0] i_run_length,
    input logic                      i_run_valid,
    input logic [car_pkg::VAL_W-1:0] i_run_total,
    input logic                      i_done_res
);

    // a reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_no_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_run_valid |-> i_done_res && i_run_length == '0)
        else $error("item without a run is not a clean closing item");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_run_valid |-> i_run_length >= car_pkg::RUN_START_LEN
            && i_run_total != '0)
        else $error("finished run shorter than two or not counted");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_run_length)
            && $stable(i_run_valid) && $stable(i_run_total) && $stable(i_done_res))
        else $error("stalled result changed");

endmodule

bind common_adjacency_run_finder car_checker u_car_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_run_length (o_res.run_length),
    .i_run_valid  (o_res.run_valid),
    .i_run_total  (o_res.run_total),
    .i_done_res   (o_res.done_res)
);
